// ===== hw/rtl/hsr_pkg.sv =====
`default_nettype none
package hsr_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // pipeline stage counts of the fixed parts
  localparam int UPM_STAGES = 16;
  localparam int REC_STAGES = 6;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_COLOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_TOLERANCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HUE     = 2'd3;

  localparam logic [23:0] BASE_COLOR_RST    = 24'h000000;
  localparam logic [23:0] TONE_COLOR_RST    = 24'h000000;
  localparam logic [15:0] HUE_TOLERANCE_RST = 16'd13107;
  localparam logic        CLAMP_HUE_RST     = 1'b1;

endpackage
`default_nettype wire

// ===== hw/rtl/hsr_div.sv =====
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// The dividend bits above the quotient must be below the divisor.
module hsr_div #(
  parameter int NW = 17,
  parameter int DW = 8,
  parameter int QW = 16
) (
  input  wire logic          clk,
  input  wire logic [QW-1:0] en,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] q_o
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] den_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_s;
    logic [QW-1:0] low_i;
    logic [QW-1:0] q_i;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_i = DW'(num_i[NW-1:QW]);
      assign low_i = num_i[QW-1:0];
      assign q_i   = '0;
      assign den_s = den_i;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign q_i   = q_r[k-1];
      assign den_s = den_r[k-1];
    end

    assign t  = {rem_i, low_i[QW-1]};
    assign ge = (t >= {1'b0, den_s});

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= ge ? DW'(t - {1'b0, den_s}) : t[DW-1:0];
        low_r[k] <= low_i << 1;
        q_r[k]   <= {q_i[QW-2:0], ge};
        den_r[k] <= den_s;
      end
    end
  end

  assign q_o = q_r[QW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/hsr_dly.sv =====
`default_nettype none
// Delay line with one enable per stage.
module hsr_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic [N-1:0] en,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en[0]) tap_r[0] <= d_i;
    for (int k = 1; k < N; k++) begin
      if (en[k]) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign q_o = tap_r[N-1];

endmodule
`default_nettype wire

// ===== hw/rtl/hsr_hsl.sv =====
`default_nettype none
// RGB to HSL: one setup stage, then the hue and saturation dividers side by side.
module hsr_hsl #(
  parameter int FB = 16
) (
  input  wire logic        clk,
  input  wire logic [FB+1:0] en,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output logic [FB-1:0]    h_o,
  output logic [FB:0]      s_o,
  output logic [FB:0]      l_o
);

  localparam int REP = (FB + 7) / 8;

  logic [7:0]         mx, mn, d, sden;
  logic [8:0]         sum;
  logic [10:0]        d6;
  logic signed [11:0] nm;
  logic [1:0]         lquo;
  logic [7:0]         lrem;
  logic [8*REP-1:0]   lrep;
  logic [FB:0]        lit;

  logic [10:0] num_r, d6_r;
  logic [7:0]  d_r, sden_r;
  logic [FB:0] l_r;
  logic        gray_r;

  logic [FB:0] qh, qs, ql;
  logic        gray_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d    = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    sden = (sum < 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    d6   = ({3'b0, d} << 2) + ({3'b0, d} << 1);
    priority if (red_i == mx) begin
      nm = $signed({4'b0, green_i}) - $signed({4'b0, blue_i});
    end else if (green_i == mx) begin
      nm = $signed({3'b0, d, 1'b0}) + $signed({4'b0, blue_i}) - $signed({4'b0, red_i});
    end else begin
      nm = $signed({2'b0, d, 2'b0}) + $signed({4'b0, red_i}) - $signed({4'b0, green_i});
    end
    if (nm < 0) nm = nm + $signed({1'b0, d6});
    // lightness sum / 510: split sum into 255 * quo + rem; rem / 255 in binary
    // is the byte rem repeated, so its leading bits are the floored fraction
    priority if (sum == 9'd510) begin
      lquo = 2'd2;
      lrem = 8'd0;
    end else if (sum >= 9'd255) begin
      lquo = 2'd1;
      lrem = 8'(sum - 9'd255);
    end else begin
      lquo = 2'd0;
      lrem = sum[7:0];
    end
    lrep = {REP{lrem}};
    lit  = {lquo, {(FB-1){1'b0}}} + {2'b0, lrep[8*REP-1 -: FB-1]};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_r  <= nm[10:0];
      d6_r   <= d6;
      d_r    <= d;
      sden_r <= sden;
      l_r    <= lit;
      gray_r <= (mx == mn);
    end
  end

  hsr_div #(.NW(FB+11), .DW(11), .QW(FB+1)) u_hue (
    .clk(clk), .en(en[FB+1:1]), .num_i({num_r, {FB{1'b0}}}), .den_i(d6_r), .q_o(qh)
  );

  hsr_div #(.NW(FB+8), .DW(8), .QW(FB+1)) u_sat (
    .clk(clk), .en(en[FB+1:1]), .num_i({d_r, {FB{1'b0}}}), .den_i(sden_r), .q_o(qs)
  );

  hsr_dly #(.W(FB+1), .N(FB+1)) u_lit (
    .clk(clk), .en(en[FB+1:1]), .d_i(l_r), .q_o(ql)
  );

  hsr_dly #(.W(1), .N(FB+1)) u_gray (
    .clk(clk), .en(en[FB+1:1]), .d_i(gray_r), .q_o(gray_q)
  );

  // gray pixels have hue and saturation zero
  assign h_o = gray_q ? '0 : qh[FB-1:0];
  assign s_o = gray_q ? '0 : qs;
  assign l_o = ql;

endmodule
`default_nettype wire

// ===== hw/rtl/hsr_rec.sv =====
`default_nettype none
// Hue match, HSL shift and HSL to RGB back conversion.
module hsr_rec
  import hsr_pkg::*;
#(
  parameter int FB = 16
) (
  input  wire logic                  clk,
  input  wire logic [REC_STAGES-1:0] en,
  input  wire logic [FB-1:0]         h_i,
  input  wire logic [FB:0]           s_i,
  input  wire logic [FB:0]           l_i,
  input  wire logic [FB-1:0]         bh_i,
  input  wire logic [FB:0]           bs_i,
  input  wire logic [FB:0]           bl_i,
  input  wire logic [FB-1:0]         th_i,
  input  wire logic [FB:0]           ts_i,
  input  wire logic [FB:0]           tl_i,
  input  wire logic [FB-1:0]         tol_i,
  input  wire logic                  clamp_i,
  output logic                       match_o,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o
);

  typedef enum logic [1:0] {SEL_RAMP, SEL_HIGH, SEL_LOW} sel_t;

  localparam longint ONE_I = 64'd1 << FB;
  localparam logic [FB:0]   ONE   = (FB+1)'(ONE_I);
  localparam logic [FB:0]   HALF  = (FB+1)'(ONE_I >> 1);
  localparam logic [FB:0]   THIRD = (FB+1)'(ONE_I / 3);
  localparam logic [FB:0]   TT    = (FB+1)'((2 * ONE_I) / 3);

  function automatic logic [FB:0] clamp_unit(input logic signed [FB+3:0] v);
    if (v < 0) return '0;
    if (v > $signed({3'b0, ONE})) return ONE;
    return v[FB:0];
  endfunction

  // stage 1
  logic [FB-1:0]        hue_gap, nh;
  logic signed [FB+3:0] ns_s, nl_s;
  logic [FB:0]          ns, nl;
  logic                 keep_l;
  logic                 m1_r;
  logic [FB-1:0]        nh1_r;
  logic [FB:0]          ns1_r, ls1_r;

  always_comb begin
    hue_gap = (bh_i >= h_i) ? bh_i - h_i : h_i - bh_i;
    nh      = h_i + th_i - bh_i;
    ns_s    = $signed({3'b0, s_i}) + $signed({3'b0, ts_i}) - $signed({3'b0, bs_i});
    nl_s    = $signed({3'b0, l_i}) + $signed({3'b0, tl_i}) - $signed({3'b0, bl_i});
    ns      = clamp_unit(ns_s);
    nl      = clamp_unit(nl_s);
    keep_l  = ({1'b0, th_i} > HALF) && clamp_i;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m1_r  <= (hue_gap < tol_i);
      nh1_r <= nh;
      ns1_r <= ns;
      ls1_r <= keep_l ? l_i : nl;
    end
  end

  // stage 2
  logic [2*FB+1:0] lprod;
  logic            m2_r;
  logic [FB-1:0]   nh2_r;
  logic [FB:0]     ns2_r, ls2_r, lsq2_r;

  assign lprod = ls1_r * ns1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m2_r   <= m1_r;
      nh2_r  <= nh1_r;
      ns2_r  <= ns1_r;
      ls2_r  <= ls1_r;
      lsq2_r <= lprod[2*FB:FB];
    end
  end

  // stage 3
  logic signed [FB+3:0] hi, lo;
  logic [FB:0]          t [3];
  logic [FB+3:0]        x6, x3, x2;
  sel_t                 sel [3];
  logic [FB:0]          fac [3];
  logic                 m3_r;
  logic signed [FB+3:0] hi3_r, lo3_r;
  logic [FB+1:0]        sp3_r;
  sel_t                 sel3_r [3];
  logic [FB:0]          fac3_r [3];

  always_comb begin
    if (ls2_r <= HALF) begin
      hi = $signed({3'b0, ls2_r}) + $signed({3'b0, lsq2_r});
    end else begin
      hi = $signed({3'b0, ls2_r}) + $signed({3'b0, ns2_r}) - $signed({3'b0, lsq2_r});
    end
    lo = $signed({2'b0, ls2_r, 1'b0}) - hi;

    t[0] = {1'b0, nh2_r} + THIRD;
    if (t[0] > ONE) t[0] = t[0] - ONE;
    t[1] = {1'b0, nh2_r};
    t[2] = ({1'b0, nh2_r} >= THIRD) ? {1'b0, nh2_r} - THIRD : {1'b0, nh2_r} + ONE - THIRD;

    for (int c = 0; c < 3; c++) begin
      x6 = ({3'b0, t[c]} << 2) + ({3'b0, t[c]} << 1);
      x3 = ({3'b0, t[c]} << 1) + {3'b0, t[c]};
      x2 = {3'b0, t[c]} << 1;
      fac[c] = '0;
      priority if (x6 < {3'b0, ONE}) begin
        sel[c] = SEL_RAMP;
        fac[c] = x6[FB:0];
      end else if (x2 < {3'b0, ONE}) begin
        sel[c] = SEL_HIGH;
      end else if (x3 < {2'b0, ONE, 1'b0}) begin
        sel[c] = SEL_RAMP;
        x6 = ({3'b0, TT - t[c]} << 2) + ({3'b0, TT - t[c]} << 1);
        fac[c] = x6[FB:0];
      end else begin
        sel[c] = SEL_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m3_r  <= m2_r;
      hi3_r <= hi;
      lo3_r <= lo;
      sp3_r <= (hi > lo) ? (FB+2)'(hi - lo) : '0;
      for (int c = 0; c < 3; c++) begin
        sel3_r[c] <= sel[c];
        fac3_r[c] <= fac[c];
      end
    end
  end

  // stage 4
  logic [2*FB+2:0]      cprod [3];
  logic                 m4_r;
  logic signed [FB+3:0] hi4_r, lo4_r;
  sel_t                 sel4_r [3];
  logic [FB+1:0]        pr4_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cprod[c] = sp3_r * fac3_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      m4_r  <= m3_r;
      hi4_r <= hi3_r;
      lo4_r <= lo3_r;
      for (int c = 0; c < 3; c++) begin
        sel4_r[c] <= sel3_r[c];
        pr4_r[c]  <= cprod[c][2*FB+1:FB];
      end
    end
  end

  // stage 5
  logic signed [FB+3:0] cv [3];
  logic                 m5_r;
  logic [FB:0]          v5_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      unique case (sel4_r[c])
        SEL_RAMP: cv[c] = lo4_r + $signed({2'b0, pr4_r[c]});
        SEL_HIGH: cv[c] = hi4_r;
        SEL_LOW:  cv[c] = lo4_r;
        default:  cv[c] = lo4_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      m5_r <= m4_r;
      for (int c = 0; c < 3; c++) begin
        v5_r[c] <= clamp_unit(cv[c]);
      end
    end
  end

  // stage 6: scale to a byte, v * 255 >> FB
  logic [FB+8:0] sc [3];
  logic          m6_r;
  logic [7:0]    b6_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sc[c] = {v5_r[c], 8'b0} - {8'b0, v5_r[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      m6_r <= m5_r;
      for (int c = 0; c < 3; c++) begin
        b6_r[c] <= sc[c][FB+7:FB];
      end
    end
  end

  assign match_o = m6_r;
  assign red_o   = b6_r[0];
  assign green_o = b6_r[1];
  assign blue_o  = b6_r[2];

endmodule
`default_nettype wire

// ===== hw/rtl/hsl_selective_hue_recolor_unit.sv =====
`default_nettype none
// Selective hue recolor for a stream of premultiplied ARGB pixels. One pixel is
// taken per clock while in_ready is high; each pixel passes through the
// un-premultiply division, then RGB to HSL (the hue and saturation dividers
// each retire one quotient bit per stage, lightness rides alongside) and then
// the recolor math. Throughput is one pixel per clock while the output is not
// stalled; bubbles close up when the output stalls. The base and tone colors
// are converted by two free-running HSL pipelines, so write the config
// registers only while no pixel is in flight.
module hsl_selective_hue_recolor_unit
  import hsr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_alpha,
  input  wire logic [7:0]            in_red,
  input  wire logic [7:0]            in_green,
  input  wire logic [7:0]            in_blue,
  input  wire logic                  in_last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_alpha,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue,
  output logic                       recolored,
  output logic                       out_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FB   = FRAC_BITS;
  localparam int HS_N = FB + 2;
  localparam int DEP  = UPM_STAGES + HS_N + REC_STAGES;

  // config registers
  logic [23:0] base_r, tone_r;
  logic [15:0] tol_r;
  logic        clamp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_COLOR_RST;
      tone_r  <= TONE_COLOR_RST;
      tol_r   <= HUE_TOLERANCE_RST;
      clamp_r <= CLAMP_HUE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_COLOR:    base_r  <= cfg_data[23:0];
        REG_TONE_COLOR:    tone_r  <= cfg_data[23:0];
        REG_HUE_TOLERANCE: tol_r   <= cfg_data[15:0];
        REG_CLAMP_HUE:     clamp_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // rescale the Q0.16 tolerance to FB fraction bits, truncating
  logic [FB+15:0] tol_wide;
  logic [FB-1:0]  tol;
  assign tol_wide = {tol_r, {FB{1'b0}}};
  assign tol      = tol_wide[FB+15:16];

  // valid bits and per-stage enables: a stage advances when the output is ready
  // or when it or any stage downstream of it is empty
  logic [DEP-1:0] v_r;
  logic [DEP-1:0] en;

  for (genvar k = 0; k < DEP; k++) begin : g_en
    assign en[k] = out_ready || !(&v_r[DEP-1:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < DEP; k++) begin
        if (en[k]) v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[DEP-1];

  // un-premultiply: floor(c * 255 / alpha), wrapped to a byte
  logic [UPM_STAGES-1:0] q_r, q_g, q_b;

  hsr_div #(.NW(UPM_STAGES+1), .DW(8), .QW(UPM_STAGES)) u_upm_r (
    .clk(clk), .en(en[UPM_STAGES-1:0]),
    .num_i({1'b0, 16'({in_red, 8'b0} - {8'b0, in_red})}), .den_i(in_alpha), .q_o(q_r)
  );
  hsr_div #(.NW(UPM_STAGES+1), .DW(8), .QW(UPM_STAGES)) u_upm_g (
    .clk(clk), .en(en[UPM_STAGES-1:0]),
    .num_i({1'b0, 16'({in_green, 8'b0} - {8'b0, in_green})}), .den_i(in_alpha), .q_o(q_g)
  );
  hsr_div #(.NW(UPM_STAGES+1), .DW(8), .QW(UPM_STAGES)) u_upm_b (
    .clk(clk), .en(en[UPM_STAGES-1:0]),
    .num_i({1'b0, 16'({in_blue, 8'b0} - {8'b0, in_blue})}), .den_i(in_alpha), .q_o(q_b)
  );

  // pixel HSL
  logic [FB-1:0] ph, bh, th;
  logic [FB:0]   ps, pl, bs, bl, ts, tl;

  hsr_hsl #(.FB(FB)) u_hsl_pix (
    .clk(clk), .en(en[UPM_STAGES+HS_N-1:UPM_STAGES]),
    .red_i(q_r[7:0]), .green_i(q_g[7:0]), .blue_i(q_b[7:0]),
    .h_o(ph), .s_o(ps), .l_o(pl)
  );

  // base and tone HSL run freely off the config registers
  hsr_hsl #(.FB(FB)) u_hsl_base (
    .clk(clk), .en({HS_N{1'b1}}),
    .red_i(base_r[23:16]), .green_i(base_r[15:8]), .blue_i(base_r[7:0]),
    .h_o(bh), .s_o(bs), .l_o(bl)
  );

  hsr_hsl #(.FB(FB)) u_hsl_tone (
    .clk(clk), .en({HS_N{1'b1}}),
    .red_i(tone_r[23:16]), .green_i(tone_r[15:8]), .blue_i(tone_r[7:0]),
    .h_o(th), .s_o(ts), .l_o(tl)
  );

  logic       match;
  logic [7:0] rc_r, rc_g, rc_b;

  hsr_rec #(.FB(FB)) u_rec (
    .clk(clk), .en(en[DEP-1:UPM_STAGES+HS_N]),
    .h_i(ph), .s_i(ps), .l_i(pl),
    .bh_i(bh), .bs_i(bs), .bl_i(bl),
    .th_i(th), .ts_i(ts), .tl_i(tl),
    .tol_i(tol), .clamp_i(clamp_r),
    .match_o(match), .red_o(rc_r), .green_o(rc_g), .blue_o(rc_b)
  );

  // carry the original item alongside for pass-through
  logic [32:0] pass;

  hsr_dly #(.W(33), .N(DEP)) u_pass (
    .clk(clk), .en(en),
    .d_i({in_alpha, in_red, in_green, in_blue, in_last}), .q_o(pass)
  );

  logic hit;
  assign hit = match && (pass[32:25] != 8'd0);

  assign out_alpha = hit ? 8'hFF : pass[32:25];
  assign out_red   = hit ? rc_r  : pass[24:17];
  assign out_green = hit ? rc_g  : pass[16:9];
  assign out_blue  = hit ? rc_b  : pass[8:1];
  assign recolored = hit;
  assign out_last  = pass[0];

`ifndef NO_ASSERTIONS
  // items in flight change only by what enters and leaves
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) == $countones($past(v_r))
      + int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready))))
    else $error("pipeline occupancy mismatch");

  a_recolor_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && recolored) |-> (out_alpha == 8'hFF))
    else $error("recolored item not opaque");

  a_skip_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alpha == 8'd0) |-> !recolored)
    else $error("alpha zero item recolored");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  import hsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q      = 64'd1 << 16;
  localparam longint HALF_Q     = ONE_Q >> 1;
  localparam longint THIRD_Q    = ONE_Q / 3;
  localparam longint TWO_THIRD_Q = (2 * ONE_Q) / 3;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     PIPE_DRAIN  = 80;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       recolored;
    logic       last;
  } recolor_t;

  // Holds the register image and the pixels still owed by the block.
  class recolor_scoreboard;
    logic [23:0] base_rgb;
    logic [23:0] tone_rgb;
    logic [15:0] tolerance;
    logic        keep_light;
    recolor_t    pending[$];
    int          errors;

    function new();
      base_rgb   = BASE_COLOR_RST;
      tone_rgb   = TONE_COLOR_RST;
      tolerance  = HUE_TOLERANCE_RST;
      keep_light = CLAMP_HUE_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BASE_COLOR:    base_rgb   = data;
        REG_TONE_COLOR:    tone_rgb   = data;
        REG_HUE_TOLERANCE: tolerance  = data[15:0];
        REG_CLAMP_HUE:     keep_light = data[0];
        default: ;
      endcase
    endfunction

    static function void to_hsl(longint r, longint g, longint b,
                                output longint h, output longint s, output longint l);
      longint mx, mn, sum, d, num;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sum = mx + mn;
      l = (sum << 16) / 510;
      h = 0;
      s = 0;
      if (mx != mn) begin
        d = mx - mn;
        s = (sum < 255) ? (d << 16) / sum : (d << 16) / (510 - sum);
        if (r == mx) num = g - b;
        else if (g == mx) num = 2 * d + b - r;
        else num = 4 * d + r - g;
        if (num < 0) num += 6 * d;
        h = (num << 16) / (6 * d);
      end
    endfunction

    static function longint hue_level(longint lo, longint hi, longint t);
      longint span;
      span = hi - lo;
      if (span < 0) span = 0;
      if (t < 0) t += ONE_Q;
      if (t > ONE_Q) t -= ONE_Q;
      if (6 * t < ONE_Q) return lo + ((span * (6 * t)) >>> 16);
      if (2 * t < ONE_Q) return hi;
      if (3 * t < 2 * ONE_Q) return lo + ((span * (6 * (TWO_THIRD_Q - t))) >>> 16);
      return lo;
    endfunction

    static function logic [7:0] to_byte(longint v);
      longint c;
      c = (v < 0) ? 0 : ((v > ONE_Q) ? ONE_Q : v);
      return 8'((c * 255) >>> 16);
    endfunction

    static function longint unit_clamp(longint v);
      return (v < 0) ? 0 : ((v > ONE_Q) ? ONE_Q : v);
    endfunction

    // Work out the recolored pixel for one accepted input item.
    function recolor_t recolor(pixel_t p);
      recolor_t res;
      longint a, h, s, l, bh, bs, bl, th, ts, tl, hue_gap, nh, ns, nl, lsel, lsq, hi, lo;
      res = '{p.alpha, p.red, p.green, p.blue, 1'b0, p.last};
      if (p.alpha == 0) return res;
      a = p.alpha;
      to_hsl(((longint'(p.red) * 255) / a) & 255, ((longint'(p.green) * 255) / a) & 255,
             ((longint'(p.blue) * 255) / a) & 255, h, s, l);
      to_hsl(base_rgb[23:16], base_rgb[15:8], base_rgb[7:0], bh, bs, bl);
      to_hsl(tone_rgb[23:16], tone_rgb[15:8], tone_rgb[7:0], th, ts, tl);
      hue_gap = bh - h;
      if (hue_gap < 0) hue_gap = -hue_gap;
      if (!(hue_gap < longint'(tolerance))) return res;
      nh = (h + th - bh) & (ONE_Q - 1);
      ns = unit_clamp(s + ts - bs);
      nl = unit_clamp(l + tl - bl);
      lsel = (th > HALF_Q && keep_light) ? l : nl;
      if (ns == 0) begin
        res.red = to_byte(lsel);
        res.green = res.red;
        res.blue = res.red;
      end else begin
        lsq = (lsel * ns) >>> 16;
        hi = (lsel <= HALF_Q) ? lsel + lsq : lsel + ns - lsq;
        lo = 2 * lsel - hi;
        res.red   = to_byte(hue_level(lo, hi, nh + THIRD_Q));
        res.green = to_byte(hue_level(lo, hi, nh));
        res.blue  = to_byte(hue_level(lo, hi, nh - THIRD_Q));
      end
      res.alpha = 8'd255;
      res.recolored = 1'b1;
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      pending.push_back(recolor(p));
    endfunction

    function void mismatch(string field, int exp_v, int got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, exp_v, got_v);
    endfunction

    function void check_result(recolor_t got);
      recolor_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %p", $realtime, got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.alpha !== exp_r.alpha) mismatch("out_alpha", exp_r.alpha, got.alpha);
      if (got.red !== exp_r.red) mismatch("out_red", exp_r.red, got.red);
      if (got.green !== exp_r.green) mismatch("out_green", exp_r.green, got.green);
      if (got.blue !== exp_r.blue) mismatch("out_blue", exp_r.blue, got.blue);
      if (got.recolored !== exp_r.recolored) mismatch("recolored", exp_r.recolored, got.recolored);
      if (got.last !== exp_r.last) mismatch("out_last", exp_r.last, got.last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_alpha = '0;
  logic [7:0]            in_red = '0;
  logic [7:0]            in_green = '0;
  logic [7:0]            in_blue = '0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_alpha;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  recolored;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  recolor_scoreboard sb = new();

  int cycle_count = 0;
  int pixels_taken = 0;
  int send_idle_pct = 0;   // chance per cycle that the sender holds back
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int hold_left = 0;
  bit hold_done = 1'b0;

  hsl_selective_hue_recolor_unit u_top (.*);

  always #2 clk = ~clk;

  // Cycle counter doubles as the watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off once traffic is flowing so
  // the pipeline fills and backs up into the input.
  always @(posedge clk) begin
    if (!hold_done && pixels_taken >= 400) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor both channels on the edge; values seen here are pre-edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_pixel('{in_alpha, in_red, in_green, in_blue, in_last});
      pixels_taken <= pixels_taken + 1;
    end
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_alpha, out_red, out_green, out_blue, recolored, out_last});
  end

  // Hold a write until taken; the caller drops cfg_valid after the last one.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Offer one item and hold it until taken, then idle at random.
  task automatic send_pixel(pixel_t p);
    in_valid <= 1'b1;
    in_alpha <= p.alpha;
    in_red   <= p.red;
    in_green <= p.green;
    in_blue  <= p.blue;
    in_last  <= p.last;
    do @(posedge clk); while (!in_ready);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Wait until every owed item is back, then let the pipeline go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic set_colors(logic [23:0] base_c, logic [23:0] tone_c, logic [15:0] tol,
                            logic keep);
    drain();
    write_cfg(REG_BASE_COLOR, base_c);
    write_cfg(REG_TONE_COLOR, tone_c);
    write_cfg(REG_HUE_TOLERANCE, {8'h00, tol});
    write_cfg(REG_CLAMP_HUE, {23'd0, keep});
    cfg_valid <= 1'b0;
    // give the free-running base and tone converters time to settle
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  function automatic logic [7:0] premul(int c, int a);
    return 8'((c * a) / 255);
  endfunction

  // Mostly pixels near the base hue with random alpha, so the recolor path
  // is exercised; the rest is wrapped channels, transparent pixels and noise.
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int mode, jit, a, c[3];
    mode = $urandom_range(0, 99);
    p.last = ($urandom_range(0, 7) == 0);
    p.alpha = 8'($urandom_range(1, 255));
    p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
    if (mode < 10) begin
      p.alpha = 8'd0;
    end else if (mode < 60) begin
      jit = $urandom_range(0, 12);
      a = p.alpha;
      c[0] = sb.base_rgb[23:16]; c[1] = sb.base_rgb[15:8]; c[2] = sb.base_rgb[7:0];
      for (int k = 0; k < 3; k++) begin
        c[k] = c[k] + $urandom_range(0, 2 * jit) - jit;
        if (c[k] < 0) c[k] = 0;
        if (c[k] > 255) c[k] = 255;
      end
      if ($urandom_range(0, 3) == 0) a = 255;
      p.alpha = 8'(a);
      p.red = premul(c[0], a); p.green = premul(c[1], a); p.blue = premul(c[2], a);
    end else if (mode < 70) begin
      p.alpha = 8'($urandom_range(1, 60));
    end
    return p;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: red base toward green tone, lightness follows the tone.
    set_colors(24'hff0000, 24'h00ff00, HUE_TOLERANCE_RST, 1'b1);
    send_pixel('{8'd0, 8'd255, 8'd0, 8'd0, 1'b0});     // transparent passes through
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 1'b1});
    send_pixel('{8'd255, 8'd255, 8'd0, 8'd0, 1'b0});   // exact base hue
    send_pixel('{8'd128, 8'd128, 8'd10, 8'd0, 1'b0});  // premultiplied near base
    send_pixel('{8'd255, 8'd0, 8'd0, 8'd0, 1'b0});     // black is gray, hue zero
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}); // white
    send_pixel('{8'd10, 8'd200, 8'd3, 8'd1, 1'b0});    // channel above alpha wraps
    send_pixel('{8'd255, 8'd0, 8'd255, 8'd0, 1'b0});   // green, out of tolerance
    send_pixel('{8'd255, 8'd0, 8'd0, 8'd255, 1'b0});
    send_pixel('{8'd1, 8'd1, 8'd0, 8'd0, 1'b1});
    // Tone hue above one half with lightness kept.
    set_colors(24'hff0000, 24'h0000ff, 16'hffff, 1'b1);
    send_pixel('{8'd255, 8'd255, 8'd0, 8'd0, 1'b0});
    send_pixel('{8'd255, 8'd200, 8'd30, 8'd90, 1'b0});
    send_pixel('{8'd255, 8'd40, 8'd30, 8'd20, 1'b1});
    // Gray tone drives saturation to zero; zero tolerance never matches.
    set_colors(24'h804020, 24'h808080, 16'hffff, 1'b0);
    send_pixel('{8'd255, 8'd128, 8'd64, 8'd32, 1'b0});
    send_pixel('{8'd255, 8'd250, 8'd20, 8'd5, 1'b0});
    send_pixel('{8'd255, 8'd255, 8'd254, 8'd253, 1'b1});
    set_colors(24'hffffff, 24'hffffff, 16'd0, 1'b0);
    send_pixel('{8'd255, 8'd0, 8'd0, 8'd0, 1'b0});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
    // Saturation above one clamps; lightness clamps through a bright tone.
    set_colors(24'h202020, 24'hff8000, 16'hffff, 1'b0);
    send_pixel('{8'd255, 8'd255, 8'd0, 8'd128, 1'b0});
    send_pixel('{8'd255, 8'd240, 8'd250, 8'd245, 1'b1});

    // Random phases: each with its own colors and idling mode.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_colors(24'($urandom), 24'($urandom), 16'($urandom), 1'b1);
        1: set_colors(24'h000000, 24'hffffff, 16'hffff, 1'b0);
        2: set_colors(24'($urandom), 24'h0000ff, 16'd13107, 1'b1);
        3: set_colors(24'hffffff, 24'h000000, 16'd0, 1'b1);
        4: set_colors(24'($urandom), 24'($urandom), 16'd4000, 1'b0);
        5: set_colors(24'hff00ff, 24'h00ffff, 16'd65535, 1'b1);
        6: set_colors(24'($urandom), 24'($urandom), 16'($urandom), 1'($urandom));
        default: set_colors(24'h10e020, 24'hc03070, 16'd20000, 1'b1);
      endcase
      send_idle_pct  = (ph % 4 == 1) ? 54 : ((ph % 4 == 3) ? 23 : 0);
      recv_stall_pct = (ph % 4 == 2) ? 54 : ((ph % 4 == 3) ? 23 : 0);
      for (int n = 0; n < 215; n++) send_pixel(rand_pixel());
    end

    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
